/* rtl/gyro_bias_calibrate_scale_defines.svh */
// assertion macros for the gyro bias calibration block
// no dependencies; included by files that carry concurrent checks
`ifndef GYRO_BIAS_CALIBRATE_SCALE_DEFINES_SVH
`define GYRO_BIAS_CALIBRATE_SCALE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GBCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gbcs check failed");
`define GBCS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gbcs sequence check failed");
`else
`define GBCS_ASSERT(lbl, prop)
`define GBCS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* rtl/gbcs_pkg.sv */
// shared constants and types for the gyro bias calibration block
// no dependencies
package gbcs_pkg;

  localparam int SAMPLE_COUNT = 50;
  localparam int CNT_W = 6;
  localparam int RAW_W = 16;
  localparam int ACC_W = 22;
  localparam int DIFF_W = ACC_W + 1;
  localparam int D_W = RAW_W + 1;
  localparam int RATE_W = 22;
  localparam int RATE_SHIFT = 16;

  localparam logic [CNT_W-1:0] SAMPLES = CNT_W'(SAMPLE_COUNT);

  // scale 2000/32767/20*pi/180 in Q36
  localparam int K_W = 23;
  localparam logic [K_W-1:0] RATE_K = 23'd3660332;

  // reciprocal for truncating division of a 22-bit magnitude by the sample count
  localparam int DIV_SHIFT = ACC_W + CNT_W;
  localparam int DIV_M_W = DIV_SHIFT + 1;
  localparam longint DIV_M_FULL =
    ((longint'(1) << DIV_SHIFT) + longint'(SAMPLE_COUNT) - 1) / longint'(SAMPLE_COUNT);
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_FULL);

  typedef struct packed {
    logic update;
    logic calibrating;
    logic last;
  } axis_ctl_t;

endpackage

/* rtl/gbcs_axis.sv */
// one axis: bias accumulator and divider, bias subtraction, saturation, rad/s scaling
// depends on gbcs_pkg
module gbcs_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [gbcs_pkg::RAW_W-1:0]   raw,
  input  logic                                negate,
  input  gbcs_pkg::axis_ctl_t                 ctl,
  output logic signed [gbcs_pkg::RATE_W-1:0]  rate
);

  logic signed [gbcs_pkg::ACC_W-1:0] acc;
  logic signed [gbcs_pkg::ACC_W-1:0] acc_next;
  logic signed [gbcs_pkg::ACC_W-1:0] raw_ext;
  logic signed [gbcs_pkg::ACC_W-1:0] sum;
  logic [gbcs_pkg::ACC_W-1:0] mag;
  logic [gbcs_pkg::ACC_W+gbcs_pkg::DIV_M_W-1:0] quo_prod;
  logic [gbcs_pkg::ACC_W-1:0] quo;
  logic signed [gbcs_pkg::ACC_W-1:0] bias_q;
  logic signed [gbcs_pkg::DIFF_W-1:0] diff;
  logic signed [gbcs_pkg::D_W-1:0] sat;
  logic signed [gbcs_pkg::D_W-1:0] d;
  logic signed [gbcs_pkg::K_W:0] k_s;
  logic signed [gbcs_pkg::D_W+gbcs_pkg::K_W:0] t;

  assign raw_ext = {{(gbcs_pkg::ACC_W-gbcs_pkg::RAW_W){raw[gbcs_pkg::RAW_W-1]}}, raw};
  assign sum = acc + raw_ext;

  // truncate toward zero: divide the magnitude, restore the sign
  assign mag = sum[gbcs_pkg::ACC_W-1] ? (~sum + 1'b1) : sum;
  assign quo_prod = mag * gbcs_pkg::DIV_M;
  assign quo = quo_prod[gbcs_pkg::DIV_SHIFT +: gbcs_pkg::ACC_W];
  assign bias_q = sum[gbcs_pkg::ACC_W-1] ? signed'(~quo + 1'b1) : signed'(quo);

  always_comb begin
    acc_next = acc;
    if (ctl.update && ctl.calibrating) begin
      acc_next = ctl.last ? bias_q : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  assign diff = {{(gbcs_pkg::DIFF_W-gbcs_pkg::RAW_W){raw[gbcs_pkg::RAW_W-1]}}, raw}
              - {acc[gbcs_pkg::ACC_W-1], acc};

  always_comb begin
    if (diff > 23'sd32767) begin
      sat = 17'sd32767;
    end else if (diff < -23'sd32768) begin
      sat = -17'sd32768;
    end else begin
      sat = diff[gbcs_pkg::D_W-1:0];
    end
  end

  assign d = negate ? -sat : sat;
  assign k_s = signed'({1'b0, gbcs_pkg::RATE_K});
  // round half up, then floor shift
  assign t = d * k_s + (gbcs_pkg::D_W+gbcs_pkg::K_W+1)'(32768);

  assign rate = ctl.calibrating ? '0 : t[gbcs_pkg::RATE_SHIFT +: gbcs_pkg::RATE_W];

endmodule

/* rtl/gyro_bias_calibrate_scale.sv */
// top level: input register, three axis datapaths, result register
// depends on gbcs_pkg, gbcs_axis and gyro_bias_calibrate_scale_defines.svh
//
// Takes one six-byte gyro readout per transfer and returns one result per
// transfer. The first 50 readouts are averaged into per-axis bias and return
// zero rates with calibrating high; later readouts return bias-corrected
// rates in rad/s with 20 fraction bits. One readout can be taken every cycle
// while the output does not stall; a readout goes from the input register to
// the result register, where rate_valid shows it. Each item passes once through
// the per-axis subtract, saturate and constant multiply between them; the bias
// divide on the last calibration readout is a reciprocal multiply in that pass.
`include "gyro_bias_calibrate_scale_defines.svh"
module gyro_bias_calibrate_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [7:0]                         sample_byte_0,
  input  logic [7:0]                         sample_byte_1,
  input  logic [7:0]                         sample_byte_2,
  input  logic [7:0]                         sample_byte_3,
  input  logic [7:0]                         sample_byte_4,
  input  logic [7:0]                         sample_byte_5,
  output logic                               rate_valid,
  input  logic                               rate_stall,
  output logic signed [gbcs_pkg::RATE_W-1:0] rate_x,
  output logic signed [gbcs_pkg::RATE_W-1:0] rate_y,
  output logic signed [gbcs_pkg::RATE_W-1:0] rate_z,
  output logic                               calibrating
);

  logic       s1_valid;
  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [gbcs_pkg::CNT_W-1:0] samples_left;
  logic out_load;
  logic advance;
  logic cal_now;
  gbcs_pkg::axis_ctl_t ctl;
  logic signed [gbcs_pkg::RATE_W-1:0] rx_next, ry_next, rz_next;

  assign out_load = !rate_valid || !rate_stall;
  assign advance = s1_valid && out_load;
  assign sample_stall = s1_valid && !out_load;
  assign cal_now = samples_left != '0;

  assign ctl.update = advance;
  assign ctl.calibrating = cal_now;
  assign ctl.last = samples_left == gbcs_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      b0 <= sample_byte_0;
      b1 <= sample_byte_1;
      b2 <= sample_byte_2;
      b3 <= sample_byte_3;
      b4 <= sample_byte_4;
      b5 <= sample_byte_5;
    end
    if (advance) begin
      rate_x <= rx_next;
      rate_y <= ry_next;
      rate_z <= rz_next;
      calibrating <= cal_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rate_valid <= 1'b0;
      samples_left <= gbcs_pkg::SAMPLES;
    end else begin
      if (!sample_stall) begin
        s1_valid <= sample_valid;
      end
      if (out_load) begin
        rate_valid <= s1_valid;
      end
      if (advance && cal_now) begin
        samples_left <= samples_left - 1'b1;
      end
    end
  end

  gbcs_axis u_axis_x (
    .clk    (clk),
    .rst    (rst),
    .raw    (signed'({b2, b3})),
    .negate (1'b0),
    .ctl    (ctl),
    .rate   (rx_next)
  );

  gbcs_axis u_axis_y (
    .clk    (clk),
    .rst    (rst),
    .raw    (signed'({b0, b1})),
    .negate (1'b1),
    .ctl    (ctl),
    .rate   (ry_next)
  );

  gbcs_axis u_axis_z (
    .clk    (clk),
    .rst    (rst),
    .raw    (signed'({b4, b5})),
    .negate (1'b0),
    .ctl    (ctl),
    .rate   (rz_next)
  );

  `GBCS_ASSERT(a_cnt_range, samples_left <= gbcs_pkg::SAMPLES)
  `GBCS_ASSERT(a_cal_zero, (rate_valid && calibrating) |-> (rate_x == '0 && rate_y == '0 && rate_z == '0))
  `GBCS_ASSERT_NEXT(a_cal_done_holds, samples_left == '0, samples_left == '0)
  `GBCS_ASSERT_NEXT(a_accept_fills, sample_valid && !sample_stall, s1_valid)
  `GBCS_ASSERT(a_stall_only_full, sample_stall |-> (s1_valid && rate_valid && rate_stall))

endmodule
